@@ rtl/core/csvt_pkg.sv @@
// Shared types and constants of the CSV field tokenizer.
package csvt_pkg;

    localparam int unsigned CHAR_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_LF = 16'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR = 16'd13;

    localparam logic [CHAR_W-1:0] DELIM_RESET  = 16'd44;
    localparam logic [CHAR_W-1:0] QUOTE_RESET  = 16'd34;
    localparam logic [CHAR_W-1:0] ESCAPE_RESET = 16'd92;

    // configuration register indexes
    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_QUOTE     = 2'd1;
    localparam logic [1:0] REG_ESCAPE    = 2'd2;

    // input word modes
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_EOI  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2,
        KIND_UNCLOSED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] delimiter_char;
        logic [CHAR_W-1:0] quote_char;
        logic [CHAR_W-1:0] escape_char;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] char_value;
    } token_t;

    // up to two tokens per input word, tok0 first
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } step_res_t;

endpackage

@@ rtl/core/csvt_step.sv @@
// Tokenizer state flags and the per-word next-state and token logic.
module csvt_step
    import csvt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              mode,
    input  logic [CHAR_W-1:0] char_code,
    input  cfg_t              cfg,
    output step_res_t         res
);

    logic in_quotes_reg,      in_quotes_next;
    logic quote_pend_reg,     quote_pend_next;
    logic escape_pend_reg,    escape_pend_next;
    logic field_nonempty_reg, field_nonempty_next;
    logic line_nonempty_reg,  line_nonempty_next;
    logic after_cr_reg,       after_cr_next;

    logic      is_nl;
    logic      go_outside;
    logic      go_inside;
    step_res_t res_next;

    function automatic step_res_t push(step_res_t r, kind_t k, logic [CHAR_W-1:0] ch);
        step_res_t o;
        o = r;
        if (r.cnt == 2'd0) begin
            o.tok0 = '{kind: k, char_value: ch};
        end else begin
            o.tok1 = '{kind: k, char_value: ch};
        end
        o.cnt = r.cnt + 2'd1;
        return o;
    endfunction

    assign is_nl = (char_code == CHAR_LF) || (char_code == CHAR_CR);

    always_comb begin
        in_quotes_next      = in_quotes_reg;
        quote_pend_next     = quote_pend_reg;
        escape_pend_next    = escape_pend_reg;
        field_nonempty_next = field_nonempty_reg;
        line_nonempty_next  = line_nonempty_reg;
        after_cr_next       = after_cr_reg;
        res_next            = '0;
        go_outside          = 1'b0;
        go_inside           = 1'b0;

        if (mode == MODE_EOI) begin
            // flush pending escape, then end the row or report the open quote
            if (escape_pend_reg) begin
                res_next = push(res_next, KIND_CHAR, cfg.escape_char);
            end
            if (in_quotes_reg && !quote_pend_reg) begin
                res_next = push(res_next, KIND_UNCLOSED, '0);
            end else if (line_nonempty_reg || escape_pend_reg) begin
                res_next = push(res_next, KIND_ROW_END, '0);
            end
            in_quotes_next      = 1'b0;
            quote_pend_next     = 1'b0;
            escape_pend_next    = 1'b0;
            field_nonempty_next = 1'b0;
            line_nonempty_next  = 1'b0;
            after_cr_next       = 1'b0;
        end else if (after_cr_reg && char_code == CHAR_LF) begin
            // LF of a CR LF pair
            after_cr_next = 1'b0;
        end else begin
            after_cr_next = (char_code == CHAR_CR);
            if (!in_quotes_reg) begin
                go_outside = 1'b1;
            end else if (quote_pend_reg) begin
                quote_pend_next = 1'b0;
                if (!is_nl && char_code == cfg.quote_char) begin
                    res_next            = push(res_next, KIND_CHAR, cfg.quote_char);
                    field_nonempty_next = 1'b1;
                    line_nonempty_next  = 1'b1;
                end else begin
                    in_quotes_next = 1'b0;
                    go_outside     = 1'b1;
                end
            end else if (escape_pend_reg) begin
                escape_pend_next = 1'b0;
                if (!is_nl && char_code == cfg.quote_char) begin
                    res_next            = push(res_next, KIND_CHAR, cfg.quote_char);
                    field_nonempty_next = 1'b1;
                    line_nonempty_next  = 1'b1;
                end else begin
                    res_next            = push(res_next, KIND_CHAR, cfg.escape_char);
                    field_nonempty_next = 1'b1;
                    line_nonempty_next  = 1'b1;
                    go_inside           = 1'b1;
                end
            end else begin
                go_inside = 1'b1;
            end
        end

        if (go_outside) begin
            if (is_nl) begin
                res_next            = push(res_next, KIND_ROW_END, '0);
                field_nonempty_next = 1'b0;
                line_nonempty_next  = 1'b0;
            end else if (char_code == cfg.quote_char && !field_nonempty_reg) begin
                in_quotes_next     = 1'b1;
                line_nonempty_next = 1'b1;
            end else if (char_code == cfg.delimiter_char) begin
                res_next            = push(res_next, KIND_FIELD_END, '0);
                field_nonempty_next = 1'b0;
                line_nonempty_next  = 1'b1;
            end else begin
                res_next            = push(res_next, KIND_CHAR, char_code);
                field_nonempty_next = 1'b1;
                line_nonempty_next  = 1'b1;
            end
        end

        if (go_inside) begin
            if (is_nl) begin
                res_next            = push(res_next, KIND_CHAR, CHAR_LF);
                field_nonempty_next = 1'b1;
                line_nonempty_next  = 1'b1;
            end else if (char_code == cfg.quote_char) begin
                quote_pend_next = 1'b1;
            end else if (char_code == cfg.escape_char) begin
                escape_pend_next = 1'b1;
            end else begin
                res_next            = push(res_next, KIND_CHAR, char_code);
                field_nonempty_next = 1'b1;
                line_nonempty_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg      <= 1'b0;
            quote_pend_reg     <= 1'b0;
            escape_pend_reg    <= 1'b0;
            field_nonempty_reg <= 1'b0;
            line_nonempty_reg  <= 1'b0;
            after_cr_reg       <= 1'b0;
        end else if (advance) begin
            in_quotes_reg      <= in_quotes_next;
            quote_pend_reg     <= quote_pend_next;
            escape_pend_reg    <= escape_pend_next;
            field_nonempty_reg <= field_nonempty_next;
            line_nonempty_reg  <= line_nonempty_next;
            after_cr_reg       <= after_cr_next;
        end
    end

    assign res = res_next;

endmodule

@@ rtl/core/csvt_res_fifo.sv @@
// Four-entry token queue, up to two pushes and one pop per cycle.
module csvt_res_fifo
    import csvt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  step_res_t         push_res,
    input  logic              push_en,
    output logic [2:0]        count,
    output logic              out_valid,
    input  logic              out_ready,
    output token_t            out_tok,
    output logic              out_last
);

    localparam int unsigned DEPTH = 4;

    token_t     tok_reg  [DEPTH];
    logic       last_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg,  count_next;
    logic [1:0] n_push;
    logic       pop;
    logic [1:0] wr_ptr_1;

    assign n_push   = push_en ? push_res.cnt : 2'd0;
    assign pop      = out_valid && out_ready;
    assign wr_ptr_1 = wr_ptr_reg + 2'd1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            tok_reg[wr_ptr_reg]  <= push_res.tok0;
            last_reg[wr_ptr_reg] <= (n_push == 2'd1);
        end
        if (n_push == 2'd2) begin
            tok_reg[wr_ptr_1]  <= push_res.tok1;
            last_reg[wr_ptr_1] <= 1'b1;
        end
    end

    assign count     = count_reg;
    assign out_valid = (count_reg != 3'd0);
    assign out_tok   = tok_reg[rd_ptr_reg];
    assign out_last  = last_reg[rd_ptr_reg];

endmodule

@@ rtl/core/csv_field_tokenizer.sv @@
// Top level of the streaming CSV field tokenizer.
// Path: an input word is held in the input register; its tokens are written into
//   the token queue when the word advances, and m_ is driven from the queue.
// Throughput: one input word per cycle while the queue has room for two tokens;
//   the output port carries one token at a time; a 4-entry queue absorbs them.
// Reset (aresetn low, synchronous): state flags and queue cleared, delimiter,
//   quote and escape registers return to 44, 34 and 92.
module csv_field_tokenizer
    import csvt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // input words
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,    // [15:0] char_code
    input  logic [0:0]        s_tuser,    // [0] mode

    // tokens
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,    // [15:0] char_value
    output logic [1:0]        m_tuser,    // [1:0] kind
    output logic              m_tlast,

    // configuration writes
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              advance;
    logic [2:0]        fifo_count;
    step_res_t         step_res;
    token_t            out_tok;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delimiter_char <= DELIM_RESET;
            cfg_reg.quote_char     <= QUOTE_RESET;
            cfg_reg.escape_char    <= ESCAPE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DELIMITER: cfg_reg.delimiter_char <= cfg_wdata;
                REG_QUOTE:     cfg_reg.quote_char     <= cfg_wdata;
                REG_ESCAPE:    cfg_reg.escape_char    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A word in the input register moves on when the queue has room for two
    // tokens; count is taken before this cycle's pop to keep m_tready off
    // the s_tready path.
    assign advance  = in_valid_reg && (fifo_count <= 3'd2);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser[0];
            in_char_reg <= s_tdata;
        end
    end

    csvt_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .mode      (in_mode_reg),
        .char_code (in_char_reg),
        .cfg       (cfg_reg),
        .res       (step_res)
    );

    csvt_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_res  (step_res),
        .push_en   (advance),
        .count     (fifo_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = out_tok.char_value;
    assign m_tuser = out_tok.kind;

endmodule
